// ===== rtl/elp_pkg.sv =====
// Package for the edge list text parser: transaction types, character codes
// and the decimal saturation limit. No dependencies.

package elp_pkg;

    localparam int unsigned VertexWidth = 32;
    localparam int unsigned ByteWidth   = 8;

    // Character codes
    localparam logic [ByteWidth-1:0] CHAR_HASH    = 8'h23;
    localparam logic [ByteWidth-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [ByteWidth-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [ByteWidth-1:0] CHAR_NINE    = 8'h39;

    localparam logic [VertexWidth-1:0] MAX_VALUE = '1;

    // One input transaction: a text byte and the end-of-text mark
    typedef struct packed {
        logic                 end_of_text;
        logic [ByteWidth-1:0] text_byte;
    } text_item_t;

    // One parsed edge
    typedef struct packed {
        logic                   overflowed;
        logic [VertexWidth-1:0] dest_vertex;
        logic [VertexWidth-1:0] source_vertex;
    } edge_item_t;

    // Handshake between parse core and its neighbor stages
    typedef struct packed {
        logic item_valid;  // input register holds a byte
        logic out_space;   // output register can take an edge this cycle
    } core_ctrl_in_t;

    typedef struct packed {
        logic consume;     // byte is processed this cycle
        logic emit;        // an edge is written this cycle
    } core_ctrl_out_t;

endpackage

// ===== rtl/edge_list_text_parser_unit.sv =====
// Top level of the edge list text parser.
// Depends on elp_pkg, elp_input_stage, elp_parse_core, elp_output_stage.

// Parses a text edge list, one byte per transaction, into pairs of unsigned
// 32-bit decimal vertex numbers; every completed destination yields one edge
// transaction. '#' outside a number starts a comment through the next newline,
// other non-digits separate numbers, and s_tlast marks the final byte: an open
// number completes there, a lone source is dropped and all state clears. A
// number above 32 bits saturates at all ones and sets m_tuser on its edge.
// Throughput is one byte per clock, set by the update of the parse state
// between the input and output registers; a byte is held in the input
// register and its edge in the output register. A byte that would make an
// edge waits while the output register is full and not taken.

module edge_list_text_parser_unit
    import elp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] source_vertex, [63:32] dest_vertex
    output logic        m_tuser    // [0] overflowed
);

    text_item_t     s_item;
    text_item_t     item;
    logic           item_valid;
    core_ctrl_in_t  core_in;
    core_ctrl_out_t core_out;
    edge_item_t     edge_next;
    edge_item_t     m_item;
    logic           out_space;

    assign s_item.text_byte   = s_tdata;
    assign s_item.end_of_text = s_tlast;

    elp_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .consume    (core_out.consume),
        .item_valid (item_valid),
        .item       (item)
    );

    assign core_in.item_valid = item_valid;
    assign core_in.out_space  = out_space;

    elp_parse_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_in  (core_in),
        .item     (item),
        .ctrl_out (core_out),
        .edge_out (edge_next)
    );

    elp_output_stage u_output (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (core_out.emit),
        .edge_in (edge_next),
        .space   (out_space),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_item  (m_item)
    );

    assign m_tdata = {m_item.dest_vertex, m_item.source_vertex};
    assign m_tuser = m_item.overflowed;

endmodule

// ===== rtl/elp_input_stage.sv =====
// Input register of the edge list text parser: holds one byte transaction.
// Depends on elp_pkg.

module elp_input_stage
    import elp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  text_item_t s_item,
    input  logic       consume,
    output logic       item_valid,
    output text_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    text_item_t item_reg;

    // Refill when empty or when the held byte is consumed this cycle
    assign s_ready    = !valid_reg || consume;
    assign valid_next = s_valid || (valid_reg && !consume);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/elp_parse_core.sv =====
// Parse state and per-byte update logic of the edge list text parser.
// Depends on elp_pkg.

module elp_parse_core
    import elp_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  core_ctrl_in_t  ctrl_in,
    input  text_item_t     item,
    output core_ctrl_out_t ctrl_out,
    output edge_item_t     edge_out
);

    logic [VertexWidth-1:0] acc_reg,     acc_next;
    logic                   num_reg,     num_next;
    logic [VertexWidth-1:0] src_reg,     src_next;
    logic                   pend_reg,    pend_next;
    logic                   comment_reg, comment_next;
    logic                   sat_reg,     sat_next;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [VertexWidth+3:0] times_ten;
    logic                   emit;
    logic                   consume;

    assign is_digit = (item.text_byte >= CHAR_ZERO) && (item.text_byte <= CHAR_NINE);
    assign digit    = item.text_byte[3:0];

    // acc * 10 + digit, as (acc << 3) + (acc << 1) + digit
    assign times_ten = {1'b0, acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                     + {{VertexWidth{1'b0}}, digit};

    // Next state for one byte, then end-of-text close and clear
    always_comb begin
        acc_next     = acc_reg;
        num_next     = num_reg;
        src_next     = src_reg;
        pend_next    = pend_reg;
        comment_next = comment_reg;
        sat_next     = sat_reg;
        emit         = 1'b0;
        edge_out     = '0;

        if (comment_reg) begin
            if (item.text_byte == CHAR_NEWLINE) begin
                comment_next = 1'b0;
            end
        end else if (is_digit) begin
            if (!num_reg) begin
                acc_next = {{(VertexWidth-4){1'b0}}, digit};
                num_next = 1'b1;
            end else if (times_ten[VertexWidth+3:VertexWidth] != 4'd0) begin
                acc_next = MAX_VALUE;
                sat_next = 1'b1;
            end else begin
                acc_next = times_ten[VertexWidth-1:0];
            end
        end else begin
            // Separator closes an open number
            if (num_reg) begin
                num_next = 1'b0;
                if (!pend_reg) begin
                    src_next  = acc_reg;
                    pend_next = 1'b1;
                end else begin
                    edge_out.source_vertex = src_reg;
                    edge_out.dest_vertex   = acc_reg;
                    edge_out.overflowed    = sat_reg;
                    emit                   = 1'b1;
                    pend_next              = 1'b0;
                    sat_next               = 1'b0;
                end
                acc_next = '0;
            end
            if (item.text_byte == CHAR_HASH) begin
                comment_next = 1'b1;
            end
        end

        // Final byte: complete an open destination, drop a lone source
        if (item.end_of_text) begin
            if (num_next && pend_next) begin
                edge_out.source_vertex = src_next;
                edge_out.dest_vertex   = acc_next;
                edge_out.overflowed    = sat_next;
                emit                   = 1'b1;
            end
            acc_next     = '0;
            num_next     = 1'b0;
            src_next     = '0;
            pend_next    = 1'b0;
            comment_next = 1'b0;
            sat_next     = 1'b0;
        end
    end

    // Process a byte unless its edge has nowhere to go
    assign consume          = ctrl_in.item_valid && (!emit || ctrl_in.out_space);
    assign ctrl_out.consume = consume;
    assign ctrl_out.emit    = consume && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            num_reg     <= 1'b0;
            src_reg     <= '0;
            pend_reg    <= 1'b0;
            comment_reg <= 1'b0;
            sat_reg     <= 1'b0;
        end else if (consume) begin
            acc_reg     <= acc_next;
            num_reg     <= num_next;
            src_reg     <= src_next;
            pend_reg    <= pend_next;
            comment_reg <= comment_next;
            sat_reg     <= sat_next;
        end
    end

endmodule

// ===== rtl/elp_output_stage.sv =====
// Output register of the edge list text parser: holds one edge transaction.
// Depends on elp_pkg.

module elp_output_stage
    import elp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  edge_item_t edge_in,
    output logic       space,
    output logic       m_valid,
    input  logic       m_ready,
    output edge_item_t m_item
);

    logic       valid_reg;
    logic       valid_next;
    edge_item_t edge_reg;

    // Free when empty or drained this cycle
    assign space      = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            edge_reg <= edge_in;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = edge_reg;

endmodule

// ===== tb/edge_list_text_parser_unit_tb.sv =====
// Self-checking testbench for edge_list_text_parser_unit: text bytes in, parsed edges out.
// Depends on elp_pkg and the parser RTL. A scoreboard class predicts each edge from the
// accepted bytes and checks the edges that the block returns, in order.
`timescale 1ns / 1ps

module edge_list_text_parser_unit_tb;
    import elp_pkg::*;

    localparam int CycleLimit = 300000;
    localparam int MaxReported = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] text_byte
    logic        s_tlast;   // end_of_text
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] source_vertex, [63:32] dest_vertex
    logic        m_tuser;   // [0] overflowed

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    logic [7:0] text_q[$];

    edge_list_text_parser_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Edge predictor and checker: mirrors the parse state and holds pending edges
    class edge_scoreboard;
        logic [VertexWidth-1:0] accum;
        logic [VertexWidth-1:0] held_src;
        bit in_number;
        bit src_pending;
        bit in_comment;
        bit sat_seen;
        edge_item_t pending_edges[$];
        int errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            accum = '0;
            held_src = '0;
            in_number = 0;
            src_pending = 0;
            in_comment = 0;
            sat_seen = 0;
        endfunction

        // Close the open number: either hold it as source or pair it into an edge
        function void close_number();
            edge_item_t e;
            in_number = 0;
            if (!src_pending) begin
                held_src = accum;
                src_pending = 1;
            end else begin
                e.source_vertex = held_src;
                e.dest_vertex = accum;
                e.overflowed = sat_seen;
                pending_edges = {pending_edges, e};
                src_pending = 0;
                sat_seen = 0;
            end
            accum = '0;
        endfunction

        // Accepted text byte
        function void note_byte(logic [7:0] b, logic last);
            logic [63:0] next_val;
            if (in_comment) begin
                if (b == CHAR_NEWLINE) in_comment = 0;
            end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                if (!in_number) begin
                    accum = 32'(b - CHAR_ZERO);
                    in_number = 1;
                end else begin
                    next_val = 64'(accum) * 64'd10 + 64'(b - CHAR_ZERO);
                    if (next_val > 64'(MAX_VALUE)) begin
                        accum = MAX_VALUE;
                        sat_seen = 1;
                    end else begin
                        accum = next_val[31:0];
                    end
                end
            end else begin
                if (in_number) close_number();
                if (b == CHAR_HASH) in_comment = 1;
            end
            // end of text: finish open number, drop a lone source, clear all
            if (last) begin
                if (in_number) close_number();
                clear_state();
            end
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= MaxReported) $display("ERROR: %s", msg);
        endfunction

        // Accepted edge transaction
        function void check_edge(logic [63:0] data, logic ovf);
            edge_item_t e;
            if (pending_edges.size() == 0) begin
                flag_error($sformatf("unexpected edge src=%0d dst=%0d ovf=%0b",
                                     data[31:0], data[63:32], ovf));
                return;
            end
            e = pending_edges.pop_front();
            if (data[31:0] !== e.source_vertex || data[63:32] !== e.dest_vertex ||
                ovf !== e.overflowed)
                flag_error($sformatf({"edge mismatch: exp src=%0d dst=%0d ovf=%0b, ",
                                      "got src=%0d dst=%0d ovf=%0b"},
                                     e.source_vertex, e.dest_vertex, e.overflowed,
                                     data[31:0], data[63:32], ovf));
        endfunction
    endclass

    edge_scoreboard sb = new();

    // Clock
    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        repeat (CycleLimit) @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    // Monitor: sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_edge(m_tdata, m_tuser);
        end
    end

    // Receiver back-pressure
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            m_tready = aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One byte transaction, with an optional idle gap before it
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            @(negedge aclk);
            s_tvalid = 0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1;
        s_tdata = b;
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // Append one byte to the text being built
    function automatic void add_text_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) add_text_byte(s[i]);
    endfunction

    function automatic void push_digits(input int n);
        repeat (n) add_text_byte(8'(CHAR_ZERO + $urandom_range(9)));
    endfunction

    // Random decimal number, weighted toward short ones, with boundary and overflow cases
    function automatic void push_number();
        int k;
        k = $urandom_range(99);
        if (k < 50) push_digits($urandom_range(1, 3));
        else if (k < 75) push_digits($urandom_range(4, 10));
        else if (k < 85) push_str($urandom_range(1) ? "4294967295" : "4294967296");
        else if (k < 95) push_digits($urandom_range(11, 14));
        else begin
            push_str("00");
            push_digits($urandom_range(1, 3));
        end
    endfunction

    // Separator: common whitespace or any byte that is neither digit nor hash
    function automatic void push_sep();
        logic [7:0] b;
        case ($urandom_range(4))
            0: push_str(" ");
            1: push_str("\t");
            2: push_str(",");
            3: push_str("\r\n");
            default: begin
                do b = 8'($urandom_range(255));
                while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_HASH);
                add_text_byte(b);
            end
        endcase
    endfunction

    // One random text line: mostly well-formed edges, some comments, noise, broken pairs
    function automatic void build_line();
        int k;
        k = $urandom_range(99);
        if (k < 8) begin
            repeat ($urandom_range(1, 8)) add_text_byte(8'($urandom_range(255)));
        end else if (k < 16) begin
            push_str("#");
            repeat ($urandom_range(10)) add_text_byte(8'($urandom_range(32, 126)));
            push_str("\n");
        end else begin
            push_number();
            repeat ($urandom_range(1, 2)) push_sep();
            if (k >= 24) push_number();
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1)) push_str(" ");
                push_str("#");
                push_digits($urandom_range(3));
            end
            if ($urandom_range(9) < 7) push_str("\n");
            else push_sep();
        end
    endfunction

    task automatic run_random(input int target);
        while (bytes_sent < target) begin
            build_line();
            foreach (text_q[i]) send_byte(text_q[i], $urandom_range(59) == 0);
            text_q.delete();
        end
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        bytes_sent = 0;
        send_idle_pct = 31;
        recv_idle_pct = 68;
        repeat (12) @(negedge aclk);
        aresetn = 1;

        // Directed: plain pair, saturation with hash right after a number,
        // number open at end of text, lone source dropped, extreme byte values
        // as separators, digits inside a comment
        send_text("1 2\n", 0);
        send_text("4294967296#\n0", 1);
        send_text("7", 1);
        send_byte("3", 0);
        send_byte(8'hFF, 0);
        send_byte("4", 0);
        send_byte(8'h00, 0);
        send_text("#9 9\n", 0);

        // Random phases with different idle patterns
        run_random(310);
        send_idle_pct = 68;
        recv_idle_pct = 31;
        run_random(590);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(870);

        @(negedge aclk);
        s_tvalid = 0;
        s_tlast = 0;

        // Drain outstanding edges, then watch a few more cycles for strays
        while (sb.pending_edges.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.pending_edges.size() != 0)
            sb.flag_error($sformatf("%0d edges never arrived", sb.pending_edges.size()));

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== edge_list_text_parser_unit.f =====
rtl/elp_pkg.sv
rtl/elp_input_stage.sv
rtl/elp_parse_core.sv
rtl/elp_output_stage.sv
rtl/edge_list_text_parser_unit.sv
tb/edge_list_text_parser_unit_tb.sv
